FILE: sv/fwrid_pkg.sv
// ---------------------------------------------------------------------------
// fwrid_pkg
// Shared types and constants for the task queue with delete by id.
// ---------------------------------------------------------------------------
`default_nettype none

package fwrid_pkg;

  localparam int ID_W   = 16;
  localparam int PAY_W  = 32;
  localparam int REQ_W  = 2;
  localparam int STAT_W = 2;

  localparam int QUEUE_DEPTH_DEF   = 16;
  localparam int PAYLOAD_WIDTH_DEF = 32;

  typedef enum logic [REQ_W-1:0] {
    REQ_ENQ    = 2'd0,
    REQ_DEQ    = 2'd1,
    REQ_REMOVE = 2'd2
  } req_t;

  typedef enum logic [STAT_W-1:0] {
    ST_DONE     = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_NOTFOUND = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DEQ,
    S_SCAN,
    S_SHIFT,
    S_DONE
  } state_t;

endpackage

`default_nettype wire

FILE: sv/fwrid_if.sv
// ---------------------------------------------------------------------------
// fwrid_cmd_if / fwrid_rsp_if
// Valid/ready channels for queue requests and their results.
// ---------------------------------------------------------------------------
`default_nettype none

interface fwrid_cmd_if;
  logic                         valid;
  logic                         ready;
  logic [fwrid_pkg::REQ_W-1:0]  req_type;
  logic [fwrid_pkg::ID_W-1:0]   task_id;
  logic [fwrid_pkg::PAY_W-1:0]  task_payload;

  modport source (output valid, req_type, task_id, task_payload, input ready);
  modport sink   (input valid, req_type, task_id, task_payload, output ready);
endinterface

interface fwrid_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [fwrid_pkg::STAT_W-1:0] status;
  logic [fwrid_pkg::ID_W-1:0]   out_id;
  logic [fwrid_pkg::PAY_W-1:0]  out_payload;
  logic                         is_empty;

  modport source (output valid, status, out_id, out_payload, is_empty, input ready);
  modport sink   (input valid, status, out_id, out_payload, is_empty, output ready);
endinterface

`default_nettype wire

FILE: sv/fwrid_ram.sv
// ---------------------------------------------------------------------------
// fwrid_ram
// Slot store: one write port, one read port with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module fwrid_ram #(
  parameter int DEPTH = fwrid_pkg::QUEUE_DEPTH_DEF,
  parameter int WIDTH = fwrid_pkg::ID_W + fwrid_pkg::PAYLOAD_WIDTH_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

FILE: sv/fifo_with_remove_by_id.sv
// ---------------------------------------------------------------------------
// fifo_with_remove_by_id
// Task FIFO (id + payload) with enqueue, dequeue and delete-first-by-id.
// ---------------------------------------------------------------------------
//
//  channel | dir | payload                                  | handshake
//  --------+-----+------------------------------------------+-------------
//  cmd     | in  | req_type, task_id, task_payload          | valid/ready
//  rsp     | out | status, out_id, out_payload, is_empty    | valid/ready
//
//  One request at a time. Enqueue, unused code and any request that fails
//  at once go from idle to done; dequeue reads in S_DEQ first. Remove walks
//  up to count slots, one per cycle, through the single RAM read port and one
//  id comparator (scan until match, then move each later word up one slot).
//  rst (synchronous) empties the queue; slot contents are not cleared.
//  A result waiting on rsp.ready holds the sequencer in its final state,
//  but the next command is taken as soon as that result is registered.
// ---------------------------------------------------------------------------
`default_nettype none

module fifo_with_remove_by_id #(
  parameter int QUEUE_DEPTH   = fwrid_pkg::QUEUE_DEPTH_DEF,
  parameter int PAYLOAD_WIDTH = fwrid_pkg::PAYLOAD_WIDTH_DEF
) (
  input  wire logic    clk,
  input  wire logic    rst,
  fwrid_cmd_if.sink    cmd,
  fwrid_rsp_if.source  rsp
);

  localparam int AW      = $clog2(QUEUE_DEPTH);
  localparam int CW      = $clog2(QUEUE_DEPTH + 1);
  localparam int ID_W    = fwrid_pkg::ID_W;
  localparam int PAY_W   = fwrid_pkg::PAY_W;
  // stored payload bits: the port carries 32, the queue keeps the lower of PAYLOAD_WIDTH and 32
  localparam int STORE_W = (PAYLOAD_WIDTH < PAY_W) ? PAYLOAD_WIDTH : PAY_W;
  localparam int ENT_W   = ID_W + STORE_W;

  // ring pointer step with wrap at QUEUE_DEPTH
  function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] p);
    if (p == AW'(QUEUE_DEPTH - 1)) begin
      return '0;
    end
    return p + AW'(1);
  endfunction

  fwrid_pkg::state_t  state, state_next;

  // queue bookkeeping: head/tail of the ring, number of live words
  logic [AW-1:0]      head, head_next;
  logic [AW-1:0]      tail, tail_next;
  logic [CW-1:0]      count, count_next;

  // scan/shift walker
  logic [AW-1:0]      idx, idx_next;          // offset from head of rd_data
  logic [AW-1:0]      rd_ptr, rd_ptr_next;    // slot that rd_data came from
  logic [AW-1:0]      gap_ptr, gap_ptr_next;  // slot that gets the next word
  logic [ID_W-1:0]    key, key_next;

  // result staged until the output register is free
  fwrid_pkg::status_t pend_status, pend_status_next;
  logic [ID_W-1:0]    pend_id, pend_id_next;
  logic [STORE_W-1:0] pend_pay, pend_pay_next;

  // output register
  logic               res_valid;
  fwrid_pkg::status_t res_status;
  logic [ID_W-1:0]    res_id;
  logic [STORE_W-1:0] res_pay;
  logic               res_empty;
  logic               load_res;

  // RAM port
  logic               wr_en;
  logic [AW-1:0]      wr_addr;
  logic [ENT_W-1:0]   wr_data;
  logic               rd_en;
  logic [AW-1:0]      rd_addr;
  logic [ENT_W-1:0]   rd_data;

  logic [ID_W-1:0]    rd_id;
  logic               last;

  fwrid_ram #(
    .DEPTH (QUEUE_DEPTH),
    .WIDTH (ENT_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign rd_id = rd_data[ENT_W-1 -: ID_W];
  // last: rd_data holds the tail word (count is nonzero while walking)
  assign last  = (idx == AW'(count - CW'(1)));

  assign cmd.ready       = (state == fwrid_pkg::S_IDLE);
  assign rsp.valid       = res_valid;
  assign rsp.status      = res_status;
  assign rsp.out_id      = res_id;
  assign rsp.out_payload = PAY_W'(res_pay);
  assign rsp.is_empty    = res_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fwrid_pkg::S_IDLE;
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      state <= state_next;
      head  <= head_next;
      tail  <= tail_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    idx         <= idx_next;
    rd_ptr      <= rd_ptr_next;
    gap_ptr     <= gap_ptr_next;
    key         <= key_next;
    pend_status <= pend_status_next;
    pend_id     <= pend_id_next;
    pend_pay    <= pend_pay_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (load_res) begin
      res_valid <= 1'b1;
    end else if (rsp.ready) begin
      res_valid <= 1'b0;
    end
  end

  // count is already final when the result is loaded
  always_ff @(posedge clk) begin
    if (load_res) begin
      res_status <= pend_status;
      res_id     <= pend_id;
      res_pay    <= pend_pay;
      res_empty  <= (count == '0);
    end
  end

  always_comb begin
    state_next       = state;
    head_next        = head;
    tail_next        = tail;
    count_next       = count;
    idx_next         = idx;
    rd_ptr_next      = rd_ptr;
    gap_ptr_next     = gap_ptr;
    key_next         = key;
    pend_status_next = pend_status;
    pend_id_next     = pend_id;
    pend_pay_next    = pend_pay;
    load_res         = 1'b0;
    wr_en            = 1'b0;
    wr_addr          = tail;
    wr_data          = {cmd.task_id, cmd.task_payload[STORE_W-1:0]};
    rd_en            = 1'b0;
    rd_addr          = head;

    case (state)
      fwrid_pkg::S_IDLE: begin
        if (cmd.valid) begin
          pend_status_next = fwrid_pkg::ST_DONE;
          pend_id_next     = '0;
          pend_pay_next    = '0;
          state_next       = fwrid_pkg::S_DONE;
          case (fwrid_pkg::req_t'(cmd.req_type))
            fwrid_pkg::REQ_ENQ: begin
              if (count == CW'(QUEUE_DEPTH)) begin
                pend_status_next = fwrid_pkg::ST_FULL;
              end else begin
                wr_en      = 1'b1;
                tail_next  = wrap_inc(tail);
                count_next = count + CW'(1);
              end
            end
            fwrid_pkg::REQ_DEQ: begin
              if (count == '0) begin
                pend_status_next = fwrid_pkg::ST_EMPTY;
              end else begin
                rd_en      = 1'b1;
                state_next = fwrid_pkg::S_DEQ;
              end
            end
            fwrid_pkg::REQ_REMOVE: begin
              if (count == '0) begin
                pend_status_next = fwrid_pkg::ST_NOTFOUND;
              end else begin
                rd_en       = 1'b1;
                rd_ptr_next = head;
                idx_next    = '0;
                key_next    = cmd.task_id;
                state_next  = fwrid_pkg::S_SCAN;
              end
            end
            default: begin
              // unused code: no change, plain done
            end
          endcase
        end
      end

      fwrid_pkg::S_DEQ: begin
        pend_id_next  = rd_id;
        pend_pay_next = rd_data[STORE_W-1:0];
        head_next     = wrap_inc(head);
        count_next    = count - CW'(1);
        state_next    = fwrid_pkg::S_DONE;
      end

      fwrid_pkg::S_SCAN: begin
        if (rd_id == key) begin
          if (last) begin
            // match on the tail word: just pull the tail back
            count_next = count - CW'(1);
            tail_next  = rd_ptr;
            state_next = fwrid_pkg::S_DONE;
          end else begin
            gap_ptr_next = rd_ptr;
            rd_en        = 1'b1;
            rd_addr      = wrap_inc(rd_ptr);
            rd_ptr_next  = wrap_inc(rd_ptr);
            idx_next     = idx + AW'(1);
            state_next   = fwrid_pkg::S_SHIFT;
          end
        end else if (last) begin
          pend_status_next = fwrid_pkg::ST_NOTFOUND;
          state_next       = fwrid_pkg::S_DONE;
        end else begin
          rd_en       = 1'b1;
          rd_addr     = wrap_inc(rd_ptr);
          rd_ptr_next = wrap_inc(rd_ptr);
          idx_next    = idx + AW'(1);
        end
      end

      fwrid_pkg::S_SHIFT: begin
        // move the word just read one slot toward the head
        wr_en   = 1'b1;
        wr_addr = gap_ptr;
        wr_data = rd_data;
        if (last) begin
          count_next = count - CW'(1);
          tail_next  = rd_ptr;
          state_next = fwrid_pkg::S_DONE;
        end else begin
          gap_ptr_next = rd_ptr;
          rd_en        = 1'b1;
          rd_addr      = wrap_inc(rd_ptr);
          rd_ptr_next  = wrap_inc(rd_ptr);
          idx_next     = idx + AW'(1);
        end
      end

      fwrid_pkg::S_DONE: begin
        if (!res_valid || rsp.ready) begin
          load_res   = 1'b1;
          state_next = fwrid_pkg::S_IDLE;
        end
      end

      default: begin
        state_next = fwrid_pkg::S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire
